// File: hw/rtl/hcsa_pkg.sv
// Shared constants, types and the sequencer state for the chi-square accumulator.
`timescale 1ns / 1ps
package hcsa_pkg;

  localparam int unsigned DataW    = 32;
  localparam int unsigned AccW     = 48;
  localparam int unsigned DofW     = 12;
  localparam int unsigned MaxBinsDefault = 4096;
  localparam logic [AccW-1:0] AccMax = {AccW{1'b1}};
  localparam logic [DofW-1:0] DofMax = {DofW{1'b1}};

  typedef enum logic [3:0] {
    StIdle,
    StSqrtD,
    StSqrtS,
    StSqD,
    StSqS,
    StSqDiff,
    StDiv,
    StAcc,
    StFinDiv,
    StOut
  } hcsa_state_e;

endpackage

// File: hw/rtl/hcsa_serial_mul.sv
// Shift-and-add multiplier: one multiplier bit per cycle, 32 x 32 to 64 bits.
`timescale 1ns / 1ps
module hcsa_serial_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic        done_o,
  output logic [63:0] prod_o
);
  import hcsa_pkg::*;

  logic [63:0] acc_q, acc_d;
  logic [63:0] mcand_q, mcand_d;
  logic [31:0] mplier_q, mplier_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        done_q, done_d;

  always_comb begin
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (start_i) begin
      acc_d    = '0;
      mcand_d  = {32'd0, a_i};
      mplier_d = b_i;
      cnt_d    = '0;
      busy_d   = 1'b1;
    end else if (busy_q) begin
      if (mplier_q[0]) begin
        acc_d = acc_q + mcand_q;
      end
      mcand_d  = mcand_q << 1;
      mplier_d = mplier_q >> 1;
      cnt_d    = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// File: hw/rtl/histogram_chi_square_accumulator.sv
// Top level of the histogram chi-square accumulator with a bit-serial datapath.
`timescale 1ns / 1ps
//  channel | direction | signals
//  --------+-----------+-------------------------------------------------------
//  bin     | in        | in_valid_i/in_ready_o, data/sim count and error, last
//  result  | out       | out_valid_o/out_ready_i, chi2, ndf, chi2 per ndf, flag
//
// One word at a time. Each bin runs two square roots (both always run), three
// squarings (data error, sim error and difference), a restoring divide and the
// accept and accumulate steps; a bin with zero variance skips the divide.
// A last bin adds a 48-step divide for chi2 per ndf and an output load.
// Reset clears the sums and the sequencer. A result waits in its output register
// while new words are taken; the next last bin holds until that register is free.
module histogram_chi_square_accumulator #(
  parameter int unsigned MaxBins = hcsa_pkg::MaxBinsDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic signed [31:0]           data_count_i,
  input  logic signed [31:0]           sim_count_i,
  input  logic [31:0]                  data_error_i,
  input  logic [31:0]                  sim_error_i,
  input  logic                         last_bin_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [hcsa_pkg::AccW-1:0]    chi_square_o,
  output logic [hcsa_pkg::DofW-1:0]    degrees_of_freedom_o,
  output logic [hcsa_pkg::AccW-1:0]    chi_square_per_dof_o,
  output logic                         overflowed_o
);
  import hcsa_pkg::*;

  localparam int unsigned CntW = $clog2(MaxBins + 1);

  hcsa_state_e state_q, state_d;

  // Latched bin.
  logic signed [31:0] dc_q, sc_q;
  logic [31:0] de_q, de_d, se_q, se_d;
  logic        last_q;

  // Running state.
  logic [AccW-1:0] sum_q, sum_d;
  logic [CntW-1:0] used_q, used_d;
  logic            sat_q, sat_d;

  // Variance.
  logic [64:0] var_q, var_d;

  // Serial square root: two radicand bits per cycle, 48-bit radicand.
  logic [47:0] rad_q, rad_d;
  logic [25:0] rem_q, rem_d;
  logic [23:0] root_q, root_d;

  // Shared restoring divider: remainder and quotient shift one bit a cycle.
  logic [80:0] drem_q, drem_d;
  logic [79:0] num_q, num_d;
  logic [47:0] quo_q, quo_d;
  logic        big_q, big_d;
  logic [6:0]  cnt_q, cnt_d;

  // Output register.
  logic [AccW-1:0] chi_q, chi_d, per_q, per_d;
  logic [DofW-1:0] dof_q, dof_d;
  logic            ovf_q, ovf_d;
  logic            ov_q, ov_d;

  // Multiplier hookup.
  logic        mul_start;
  logic [31:0] mul_a;
  logic        mul_done;
  logic [63:0] mul_p;

  hcsa_serial_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .a_i    (mul_a),
    .b_i    (mul_a),
    .done_o (mul_done),
    .prod_o (mul_p)
  );

  logic signed [32:0] diff;
  logic [31:0]        adiff;
  logic [25:0]        trial;
  logic [80:0]        dshift;
  logic [AccW:0]      sum_ext;
  logic [CntW-1:0]    ndf_full;
  logic [DofW-1:0]    ndf;
  logic               in_fire;

  assign diff  = {dc_q[31], dc_q} - {sc_q[31], sc_q};
  assign adiff = diff[32] ? 32'(-diff) : diff[31:0];
  assign trial = {rem_q[23:0], rad_q[47:46]} - {root_q, 2'b01};
  assign in_fire = in_valid_i && in_ready_o;
  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    ndf_full = (used_q != '0) ? used_q - CntW'(1) : '0;
    if (ndf_full > CntW'(DofMax)) begin
      ndf = DofMax;
    end else begin
      ndf = DofW'(ndf_full);
    end
  end

  always_comb begin
    state_d = state_q;
    de_d = de_q; se_d = se_q;
    sum_d = sum_q; used_d = used_q; sat_d = sat_q;
    var_d = var_q;
    rad_d = rad_q; rem_d = rem_q; root_d = root_q;
    drem_d = drem_q; num_d = num_q; quo_d = quo_q; big_d = big_q; cnt_d = cnt_q;
    chi_d = chi_q; per_d = per_q; dof_d = dof_q; ovf_d = ovf_q;
    ov_d = ov_q;
    mul_start = 1'b0;
    mul_a = de_q;
    dshift = '0;
    sum_ext = '0;
    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end
    unique case (state_q)
      StIdle: begin
        if (in_fire) begin
          de_d = data_error_i;
          se_d = sim_error_i;
          rad_d = {data_count_i[31] ? 32'd0 : data_count_i, 16'd0};
          rem_d = '0; root_d = '0; cnt_d = '0;
          state_d = StSqrtD;
        end
      end
      StSqrtD, StSqrtS: begin
        rem_d = trial[25] ? {rem_q[23:0], rad_q[47:46]} : trial;
        root_d = {root_q[22:0], ~trial[25]};
        rad_d = rad_q << 2;
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd23) begin
          cnt_d = '0;
          if (state_q == StSqrtD) begin
            if (de_q == '0) de_d = {8'd0, root_d};
            rad_d = {sc_q[31] ? 32'd0 : sc_q, 16'd0};
            state_d = StSqrtS;
          end else begin
            if (se_q == '0) se_d = {8'd0, root_d};
            mul_start = 1'b1;
            state_d = StSqD;
          end
          rem_d = '0; root_d = '0;
        end
      end
      StSqD: begin
        if (mul_done) begin
          var_d = {1'b0, mul_p};
          mul_a = se_q;
          mul_start = 1'b1;
          state_d = StSqS;
        end
      end
      StSqS: begin
        mul_a = se_q;
        if (mul_done) begin
          var_d = var_q + {1'b0, mul_p};
          mul_a = adiff;
          mul_start = 1'b1;
          state_d = StSqDiff;
        end
      end
      StSqDiff: begin
        mul_a = adiff;
        if (mul_done) begin
          if (var_q == '0) begin
            state_d = StAcc;
          end else begin
            num_d = {mul_p, 16'd0};
            drem_d = '0; quo_d = '0; big_d = 1'b0; cnt_d = '0;
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        dshift = {drem_q[79:0], num_q[79]};
        num_d = num_q << 1;
        if (dshift >= {16'd0, var_q}) begin
          drem_d = dshift - {16'd0, var_q};
          if (cnt_q < 7'd32) begin
            big_d = 1'b1;
          end
          quo_d = {quo_q[46:0], 1'b1};
        end else begin
          drem_d = dshift;
          quo_d = {quo_q[46:0], 1'b0};
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd79) begin
          state_d = StAcc;
        end
      end
      StAcc: begin
        if (var_q != '0) begin
          sum_ext = {1'b0, sum_q} + {1'b0, quo_q};
          if (big_q || sum_ext[AccW]) begin
            sum_d = AccMax;
            sat_d = 1'b1;
          end else begin
            sum_d = sum_ext[AccW-1:0];
          end
          if (used_q < CntW'(MaxBins)) begin
            used_d = used_q + CntW'(1);
          end
        end
        state_d = last_q ? StFinDiv : StIdle;
        cnt_d = '0; drem_d = '0; quo_d = '0;
        num_d = {sum_d, 32'd0};
      end
      StFinDiv: begin
        // Divide the accumulator by ndf, one quotient bit a cycle.
        dshift = {drem_q[79:0], num_q[79]};
        num_d = num_q << 1;
        if (dshift >= {69'd0, ndf}) begin
          drem_d = dshift - {69'd0, ndf};
          quo_d = {quo_q[46:0], 1'b1};
        end else begin
          drem_d = dshift;
          quo_d = {quo_q[46:0], 1'b0};
        end
        cnt_d = cnt_q + 7'd1;
        if (cnt_q == 7'd47) begin
          state_d = StOut;
        end
      end
      StOut: begin
        if (!ov_q) begin
          chi_d = sum_q;
          dof_d = ndf;
          per_d = (ndf != '0) ? quo_q : '0;
          ovf_d = sat_q;
          ov_d = 1'b1;
          sum_d = '0; used_d = '0; sat_d = 1'b0;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sum_q <= '0;
      used_q <= '0;
      sat_q <= 1'b0;
      ov_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      sum_q <= sum_d;
      used_q <= used_d;
      sat_q <= sat_d;
      ov_q <= ov_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dc_q <= data_count_i;
      sc_q <= sim_count_i;
      last_q <= last_bin_i;
    end
    de_q <= de_d; se_q <= se_d;
    var_q <= var_d;
    rad_q <= rad_d; rem_q <= rem_d; root_q <= root_d;
    drem_q <= drem_d; num_q <= num_d; quo_q <= quo_d; big_q <= big_d;
    chi_q <= chi_d; per_q <= per_d; dof_q <= dof_d; ovf_q <= ovf_d;
  end

  assign out_valid_o          = ov_q;
  assign chi_square_o         = chi_q;
  assign degrees_of_freedom_o = dof_q;
  assign chi_square_per_dof_o = per_q;
  assign overflowed_o         = ovf_q;

endmodule

// File: test/tb_histogram_chi_square_accumulator.sv
// Testbench for the histogram chi-square accumulator: directed table, random histograms, stalls.
`timescale 1ns / 1ps
module tb_histogram_chi_square_accumulator;
  import hcsa_pkg::*;

  typedef struct packed {
    logic [AccW-1:0] chi;
    logic [DofW-1:0] dof;
    logic [AccW-1:0] per_dof;
    logic            ovf;
  } chi_result_t;

  typedef struct packed {
    logic signed [31:0] dc;
    logic signed [31:0] sc;
    logic [31:0]        de;
    logic [31:0]        se;
    logic               last;
    logic               typed;
    chi_result_t        res;
  } bin_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic signed [31:0] data_count_i = '0;
  logic signed [31:0] sim_count_i = '0;
  logic [31:0] data_error_i = '0;
  logic [31:0] sim_error_i = '0;
  logic last_bin_i = 1'b0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [AccW-1:0] chi_square_o;
  logic [DofW-1:0] degrees_of_freedom_o;
  logic [AccW-1:0] chi_square_per_dof_o;
  logic overflowed_o;

  // Shadow of the running sums.
  logic [AccW-1:0] chi_sum;
  int unsigned     bins_used;
  logic            chi_sat;

  chi_result_t pending_results[$];
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned recv_hold = 0;
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned results_seen = 0;
  int unsigned saturations = 0;

  histogram_chi_square_accumulator u_top (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #20_000_000;
    $display("FAIL histogram_chi_square_accumulator");
    $finish;
  end

  function automatic logic [63:0] root_q16(logic signed [31:0] content);
    logic [63:0] n;
    logic [63:0] r;
    logic [63:0] c;
    n = {16'd0, content, 16'd0};
    r = '0;
    for (int i = 23; i >= 0; i--) begin
      c = r | (64'd1 << i);
      if (c * c <= n) r = c;
    end
    return r;
  endfunction

  // Advances the shadow sums by one bin; returns 1 and the result on a last bin.
  function automatic bit chi_square_step(input logic signed [31:0] dc, input logic signed [31:0] sc,
                                         input logic [31:0] de_in, input logic [31:0] se_in,
                                         input logic last, output chi_result_t res);
    logic [63:0]  de;
    logic [63:0]  se;
    logic [65:0]  variance;
    logic signed [63:0] diff;
    logic [63:0]  ad;
    logic [127:0] quot;
    logic [AccW-1:0] ndf;
    de = (de_in != 0) ? 64'(de_in) : (dc > 0 ? root_q16(dc) : 64'd0);
    se = (se_in != 0) ? 64'(se_in) : (sc > 0 ? root_q16(sc) : 64'd0);
    variance = 66'(de * de) + 66'(se * se);
    res = '0;
    if (variance != 0) begin
      diff = 64'(dc) - 64'(sc);
      ad = (diff < 0) ? 64'(-diff) : 64'(diff);
      quot = {32'd0, ad * ad, 16'd0} / 128'(variance);
      if (quot > 128'(AccMax - chi_sum)) begin
        chi_sum = AccMax;
        chi_sat = 1'b1;
      end else begin
        chi_sum = chi_sum + quot[AccW-1:0];
      end
      if (bins_used < MaxBinsDefault) bins_used++;
    end
    if (!last) return 1'b0;
    ndf = (bins_used > 0) ? AccW'(bins_used - 1) : '0;
    if (ndf > AccW'(DofMax)) ndf = AccW'(DofMax);
    res.chi = chi_sum;
    res.dof = ndf[DofW-1:0];
    res.per_dof = (ndf != 0) ? chi_sum / ndf : '0;
    res.ovf = chi_sat;
    chi_sum = '0;
    bins_used = 0;
    chi_sat = 1'b0;
    return 1'b1;
  endfunction

  // Offers one word and waits for it to be taken; the expectation is queued on acceptance.
  task automatic send_bin(input bin_row_t row);
    chi_result_t res;
    data_count_i <= row.dc;
    sim_count_i <= row.sc;
    data_error_i <= row.de;
    sim_error_i <= row.se;
    last_bin_i <= row.last;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    words_sent++;
    if (chi_square_step(row.dc, row.sc, row.de, row.se, row.last, res)) begin
      if (res.ovf) saturations++;
      pending_results = {pending_results, (row.typed ? row.res : res)};
    end
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] pick_count();
    case ($urandom_range(9))
      0, 1:    return $urandom;
      2:       return 32'h7FFF_FFFF;
      3:       return 32'h8000_0000;
      4:       return '0;
      5, 6:    return -$urandom_range(0, 1 << 22);
      default: return $urandom_range(0, 1 << 22);
    endcase
  endfunction

  function automatic logic [31:0] pick_error();
    case ($urandom_range(9))
      0, 1, 2, 3: return '0;
      4:          return $urandom;
      5:          return 32'hFFFF_FFFF;
      default:    return $urandom_range(1, 1 << 20);
    endcase
  endfunction

  always @(posedge clk_i) begin
    if (recv_hold > 0) begin
      recv_hold <= recv_hold - 1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result chi=%h dof=%h", $time, chi_square_o,
                 degrees_of_freedom_o);
        mismatches++;
      end else begin
        chi_result_t want;
        want = pending_results.pop_front();
        if (want.chi !== chi_square_o) begin
          $display("%0t: chi_square expected %h actual %h", $time, want.chi, chi_square_o);
          mismatches++;
        end
        if (want.dof !== degrees_of_freedom_o) begin
          $display("%0t: degrees_of_freedom expected %h actual %h", $time, want.dof,
                   degrees_of_freedom_o);
          mismatches++;
        end
        if (want.per_dof !== chi_square_per_dof_o) begin
          $display("%0t: chi_square_per_dof expected %h actual %h", $time, want.per_dof,
                   chi_square_per_dof_o);
          mismatches++;
        end
        if (want.ovf !== overflowed_o) begin
          $display("%0t: overflowed expected %b actual %b", $time, want.ovf, overflowed_o);
          mismatches++;
        end
      end
    end
  end

  bin_row_t directed[$];

  initial begin
    bin_row_t row;
    int unsigned len;
    chi_sum = '0;
    bins_used = 0;
    chi_sat = 1'b0;
    // A zero row with no errors is a skipped bin; a lone one reports all zeros.
    directed = '{
      '{0, 0, 0, 0, 1, 1, '{48'd0, 12'd0, 48'd0, 1'b0}},
      '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1,
        '{48'd0, 12'd0, 48'd0, 1'b0}},
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'd1, 32'd0, 1, 1,
        '{AccMax, 12'd0, 48'd0, 1'b1}},
      '{32'h8000_0000, 32'h7FFF_FFFF, 32'd0, 32'd0, 1, 0, '0},
      '{32'h0001_0000, 32'h0003_0000, 0, 0, 0, 0, '0},
      '{32'h0004_0000, 32'h0000_0000, 0, 0, 0, 0, '0},
      '{-32'sh0002_0000, 32'h0001_0000, 0, 32'h0000_8000, 0, 0, '0},
      '{32'h0010_0000, 32'h0008_0000, 32'h0001_0000, 0, 1, 0, '0},
      '{32'h0123_4567, 32'h0000_0001, 0, 0, 0, 0, '0},
      '{-32'sd5, -32'sd9, 0, 0, 1, 0, '0},
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'd92682, 32'd0, 0, 0, '0},
      '{32'h7FFF_FFFF, 32'h8000_0000, 32'd92682, 32'd0, 0, 0, '0},
      '{32'h0000_0001, 32'h0000_0000, 32'd1, 32'd1, 1, 0, '0},
      '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, '0},
      '{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 0, 0, '0},
      '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 1, 0, '0}
    };
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_bin(directed[i]);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 49 : 0;
      recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 35 : 0;
      // The receiver stalls long enough for a result to back up into the input.
      if (phase == 2) recv_hold = 3000;
      for (int n = 0; n < 430; n += len) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 12);
        for (int k = 0; k < len; k++) begin
          row = '0;
          row.dc = pick_count();
          row.sc = ($urandom_range(3) == 0) ? row.dc + $urandom_range(0, 1 << 16) - (1 << 15)
                                            : pick_count();
          row.de = pick_error();
          row.se = pick_error();
          row.last = (k == len - 1);
          send_bin(row);
        end
      end
    end
    in_valid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
    $display("Sent %0d bins in directed and random histograms; checked %0d results.",
             words_sent, results_seen);
    $display("Results with a saturated sum: %0d; mismatches: %0d.", saturations, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS histogram_chi_square_accumulator");
    end else begin
      $display("FAIL histogram_chi_square_accumulator");
    end
    $finish;
  end

endmodule
